/* src/gcr_pkg.sv */
// Shared types and constants for the GC-content region finder.
package gcr_pkg;

	// Characters that count as GC
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;

	// Percent scale of the qualify test
	localparam int GC_SCALE = 100;

	// Field widths
	localparam int PCT_W    = 7;
	localparam int WLEN_W   = 13;
	localparam int COUNT_W  = 13;
	localparam int REGLEN_W = 32;
	localparam int OUT_W    = 32;

	// Window count saturates here
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = 3;
	localparam int FIFO_CNT_W = 4;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_MIN_GC     = 2'd0,
		REG_MAX_GC     = 2'd1,
		REG_WIN_LEN    = 2'd2,
		REG_MAX_REGION = 2'd3
	} reg_idx_t;

	// Window stage status handed to the region stage
	typedef struct packed {
		logic valid;
		logic qualify;
		logic last;
	} win_stat_t;

	// One result transaction
	typedef struct packed {
		logic [OUT_W-1:0] region_start;
		logic [OUT_W-1:0] region_length;
		logic             region_valid;
		logic             end_of_sequence;
	} result_t;

endpackage

/* src/gcr_ifs.sv */
// Stream interfaces: sequence bases in, regions out.
interface gcr_base_if;
	logic       valid;
	logic       ready;
	logic [7:0] base;
	logic       last_base;

	modport source (output valid, output base, output last_base, input ready);
	modport sink (input valid, input base, input last_base, output ready);
endinterface

interface gcr_region_if;
	logic        valid;
	logic        ready;
	logic [31:0] region_start;
	logic [31:0] region_length;
	logic        region_valid;
	logic        end_of_sequence;

	modport source (output valid, output region_start, output region_length,
		output region_valid, output end_of_sequence, input ready);
	modport sink (input valid, input region_start, input region_length,
		input region_valid, input end_of_sequence, output ready);
endinterface

/* src/gc_content_region_finder.sv */
// A base passes the stage 1 and stage 2 registers before its results enter the queue.
// Throughput: one base per cycle; input ready drops only while the 8-entry result
// queue lacks room for the results of all bases in flight (up to two each).
// Reset (arst_n low, asynchronous): stream state, queue and registers return to
// their defaults; the GC history memory is not cleared and needs no clearing pass.
module gc_content_region_finder #(
	parameter int WINDOW_MAX    = 4096,
	parameter int POSITION_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	gcr_base_if.sink    bases,
	gcr_region_if.source regions
);
	import gcr_pkg::*;

	localparam int LW = $clog2(WINDOW_MAX + 1);
	localparam int PB = POSITION_BITS;
	localparam int XW = (PB > OUT_W) ? PB : OUT_W;

	// Configuration registers
	logic [PCT_W-1:0]    min_gc_q;
	logic [PCT_W-1:0]    max_gc_q;
	logic [WLEN_W-1:0]   win_len_q;
	logic [REGLEN_W-1:0] max_region_q;
	reg_idx_t            reg_idx;
	logic                cfg_wr;
	logic [LW-1:0]       eff_len;

	// Stream state
	logic          accept;
	logic          v_s1;
	logic [PB-1:0] pos_q;
	logic [PB-1:0] pos_s1;
	logic [PB-1:0] start_s2;
	logic [PB-1:0] posp1_s2;
	win_stat_t     win_s2;

	// Pending region
	logic          pend_valid_q;
	logic [PB-1:0] pend_start_q;
	logic [PB-1:0] pend_len_q;
	logic          merge;
	logic          gap_push;
	logic          end_push;
	logic          nxt_valid;
	logic [PB-1:0] nxt_start;
	logic [PB-1:0] nxt_len;
	logic          rep_cur;
	logic          rep_nxt;
	result_t       gap_res;
	result_t       end_res;
	result_t       push0;
	logic [1:0]    push_cnt;
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic [FIFO_CNT_W:0]   need;

	// APB register access
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gc_q     <= PCT_W'(20);
			max_gc_q     <= PCT_W'(40);
			win_len_q    <= WLEN_W'(50);
			max_region_q <= REGLEN_W'(1000);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MIN_GC:     min_gc_q     <= pwdata[PCT_W-1:0];
				REG_MAX_GC:     max_gc_q     <= pwdata[PCT_W-1:0];
				REG_WIN_LEN:    win_len_q    <= pwdata[WLEN_W-1:0];
				REG_MAX_REGION: max_region_q <= pwdata[REGLEN_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MIN_GC:     prdata = 32'(min_gc_q);
			REG_MAX_GC:     prdata = 32'(max_gc_q);
			REG_WIN_LEN:    prdata = 32'(win_len_q);
			REG_MAX_REGION: prdata = 32'(max_region_q);
		endcase
	end

	// Effective window length: zero acts as one, clamp to the history depth
	always_comb begin
		if (win_len_q == '0) begin
			eff_len = LW'(1);
		end else if (32'(win_len_q) > 32'(WINDOW_MAX)) begin
			eff_len = LW'(WINDOW_MAX);
		end else begin
			eff_len = LW'(win_len_q);
		end
	end

	// Input admission: reserve queue room for every base in flight
	assign need         = (FIFO_CNT_W + 1)'(fifo_cnt) + (FIFO_CNT_W + 1)'({v_s1, 1'b0})
		+ (FIFO_CNT_W + 1)'({win_s2.valid, 1'b0}) + (FIFO_CNT_W + 1)'(2);
	assign bases.ready  = need <= (FIFO_CNT_W + 1)'(FIFO_DEPTH);
	assign accept       = bases.valid && bases.ready;

	gcr_window #(
		.WINDOW_MAX (WINDOW_MAX),
		.LW         (LW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.base      (bases.base),
		.last_base (bases.last_base),
		.eff_len   (eff_len),
		.min_pct   (min_gc_q),
		.max_pct   (max_gc_q),
		.stat_s2   (win_s2)
	);

	// Base position, cleared after the last base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				pos_q <= bases.last_base ? '0 : pos_q + 1'b1;
			end
		end
	end

	// Position pipeline alongside the window stages
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= pos_q;
		end
		if (v_s1) begin
			start_s2 <= pos_s1 + 1'b1 - PB'(eff_len);
			posp1_s2 <= pos_s1 + 1'b1;
		end
	end

	// Region merge and emission
	always_comb begin
		merge     = pend_valid_q && ((start_s2 - pend_start_q) <= pend_len_q);
		rep_cur   = pend_valid_q && (XW'(pend_len_q) <= XW'(max_region_q));
		nxt_valid = pend_valid_q;
		nxt_start = pend_start_q;
		nxt_len   = pend_len_q;
		gap_push  = 1'b0;
		if (win_s2.valid && win_s2.qualify) begin
			if (merge) begin
				nxt_len = posp1_s2 - pend_start_q;
			end else begin
				gap_push  = rep_cur;
				nxt_start = start_s2;
				nxt_len   = PB'(eff_len);
				nxt_valid = 1'b1;
			end
		end
		rep_nxt  = nxt_valid && (XW'(nxt_len) <= XW'(max_region_q));
		end_push = win_s2.valid && win_s2.last;
	end

	// Result formatting: start keeps low bits, length saturates
	function automatic result_t make_res(input logic [PB-1:0] start, input logic [PB-1:0] len,
		input logic eos);
		logic [XW-1:0] s_x;
		logic [XW-1:0] l_x;
		result_t       r;
		s_x               = XW'(start);
		l_x               = XW'(len);
		r.region_start    = s_x[OUT_W-1:0];
		r.region_length   = (l_x > XW'({OUT_W{1'b1}})) ? '1 : l_x[OUT_W-1:0];
		r.region_valid    = 1'b1;
		r.end_of_sequence = eos;
		return r;
	endfunction

	always_comb begin
		gap_res = make_res(pend_start_q, pend_len_q, 1'b0);
		if (rep_nxt) begin
			end_res = make_res(nxt_start, nxt_len, 1'b1);
		end else begin
			end_res = '{region_start: '0, region_length: '0, region_valid: 1'b0,
				end_of_sequence: 1'b1};
		end
		push0    = gap_push ? gap_res : end_res;
		push_cnt = 2'(gap_push) + 2'(end_push);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_start_q <= '0;
			pend_len_q   <= '0;
		end else if (win_s2.valid) begin
			if (win_s2.last) begin
				pend_valid_q <= 1'b0;
				pend_start_q <= '0;
				pend_len_q   <= '0;
			end else begin
				pend_valid_q <= nxt_valid;
				pend_start_q <= nxt_start;
				pend_len_q   <= nxt_len;
			end
		end
	end

	gcr_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push0    (push0),
		.push1    (end_res),
		.count    (fifo_cnt),
		.regions  (regions)
	);

`ifndef ASSERT_OFF
	// Admission control must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		((FIFO_CNT_W + 1)'(fifo_cnt) + (FIFO_CNT_W + 1)'(push_cnt))
			<= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
		else $error("result queue overflow");

	// A result without a region is only the bare end marker
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(regions.valid && !regions.region_valid) |->
			(regions.end_of_sequence && (regions.region_start == '0)
				&& (regions.region_length == '0)))
		else $error("result without region is not a clean end marker");

	// Pending region is gone after the last base
	a_seq_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(win_s2.valid && win_s2.last) |=> !pend_valid_q)
		else $error("pending region survived sequence end");
`endif

endmodule

/* src/gcr_window.sv */
// Sliding window: GC history memory, running count and percent qualify test.
module gcr_window #(
	parameter int WINDOW_MAX = 4096,
	parameter int LW = $clog2(WINDOW_MAX + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [7:0]               base,
	input  logic                     last_base,
	input  logic [LW-1:0]            eff_len,
	input  logic [gcr_pkg::PCT_W-1:0] min_pct,
	input  logic [gcr_pkg::PCT_W-1:0] max_pct,
	output gcr_pkg::win_stat_t       stat_s2
);
	import gcr_pkg::*;

	localparam int AW = $clog2(WINDOW_MAX);
	localparam int CW = (PCT_W + LW > 20) ? PCT_W + LW : 20;

	logic          hist_mem [WINDOW_MAX];
	logic [AW-1:0] wp_q;
	logic [LW-1:0] fill_q;
	logic [LW-1:0] fill_inc;
	logic [AW-1:0] rd_addr;
	logic [LW:0]   wp_x;
	logic [LW:0]   len_x;
	logic          is_gc;

	logic          v_s1;
	logic          gc_s1;
	logic          last_s1;
	logic          dec_s1;
	logic          tst_s1;
	logic          rd_s1;

	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] cnt_dec;
	logic [COUNT_W-1:0] cnt_new;
	logic [CW-1:0]      scaled;
	logic [CW-1:0]      min_prod_q;
	logic [CW-1:0]      max_prod_q;
	logic               qualify;

	// Read slot of the base that leaves the window
	assign is_gc    = (base == CHAR_C) || (base == CHAR_G);
	assign fill_inc = (fill_q < LW'(WINDOW_MAX)) ? fill_q + 1'b1 : fill_q;
	assign wp_x     = (LW + 1)'(wp_q);
	assign len_x    = (LW + 1)'(eff_len);

	always_comb begin
		if (wp_x >= len_x) begin
			rd_addr = AW'(wp_x - len_x);
		end else begin
			rd_addr = AW'(wp_x + (LW + 1)'(WINDOW_MAX) - len_x);
		end
	end

	// History memory: write the new bit, read the leaving bit
	always_ff @(posedge clk) begin
		if (accept) begin
			hist_mem[wp_q] <= is_gc;
			rd_s1          <= hist_mem[rd_addr];
		end
	end

	// Write pointer and fill count, cleared at sequence end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (accept) begin
			if (last_base) begin
				wp_q   <= '0;
				fill_q <= '0;
			end else begin
				wp_q   <= (wp_q == AW'(WINDOW_MAX - 1)) ? '0 : wp_q + 1'b1;
				fill_q <= fill_inc;
			end
		end
	end

	// Stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gc_s1   <= is_gc;
			last_s1 <= last_base;
			dec_s1  <= fill_q >= eff_len;
			tst_s1  <= fill_inc >= eff_len;
		end
	end

	// Threshold products; the user must keep config stable while items flow, the block does not enforce it
	always_ff @(posedge clk) begin
		min_prod_q <= CW'(min_pct) * CW'(eff_len);
		max_prod_q <= CW'(max_pct) * CW'(eff_len);
	end

	// Count update: drop the leaving base, add the new one
	always_comb begin
		cnt_dec = (dec_s1 && rd_s1 && (cnt_q != '0)) ? cnt_q - 1'b1 : cnt_q;
		cnt_new = (gc_s1 && (cnt_dec != COUNT_MAX)) ? cnt_dec + 1'b1 : cnt_dec;
		scaled  = CW'(cnt_new) * CW'(GC_SCALE);
		qualify = tst_s1 && (scaled >= min_prod_q) && (scaled <= max_prod_q);
	end

	// Running count and stage 2 status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			stat_s2 <= '0;
		end else begin
			stat_s2.valid <= v_s1;
			if (v_s1) begin
				cnt_q           <= last_s1 ? '0 : cnt_new;
				stat_s2.qualify <= qualify;
				stat_s2.last    <= last_s1;
			end
		end
	end

endmodule

/* src/gcr_result_fifo.sv */
// Result queue: takes up to two results a cycle, hands out one while the receiver is ready.
module gcr_result_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    push_cnt,
	input  gcr_pkg::result_t              push0,
	input  gcr_pkg::result_t              push1,
	output logic [gcr_pkg::FIFO_CNT_W-1:0] count,
	gcr_region_if.source                  regions
);
	import gcr_pkg::*;

	result_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wp_q;
	logic [FIFO_PTR_W-1:0]   rp_q;
	logic [FIFO_CNT_W-1:0]   cnt_q;
	logic                    pop;
	result_t                 head;

	assign pop   = regions.valid && regions.ready;
	assign count = cnt_q;
	assign head  = mem_q[rp_q];

	assign regions.valid           = cnt_q != '0;
	assign regions.region_start    = head.region_start;
	assign regions.region_length   = head.region_length;
	assign regions.region_valid    = head.region_valid;
	assign regions.end_of_sequence = head.end_of_sequence;

	// Storage
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wp_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wp_q + 1'b1] <= push1;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_PTR_W'(push_cnt);
			rp_q  <= rp_q + FIFO_PTR_W'(pop);
			cnt_q <= cnt_q + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
		end
	end

endmodule

/* dv/tb_gc_content_region_finder.sv */
// Testbench for the GC-content region finder: directed table, then random sequences vs a predictor.
`timescale 1ns / 1ps

module tb_gc_content_region_finder;
	import gcr_pkg::*;

	// History depth of the instance; small so a full window fills quickly
	localparam int WIN_MAX = 256;

	// Directed plan: a row is either a register write or one base
	typedef struct packed {
		logic        is_cfg;
		reg_idx_t    idx;
		logic [31:0] val;
		logic [7:0]  b;
		logic        last;
		logic        typed;
		result_t     res;
	} plan_row_t;

	localparam result_t NO_RES   = '0;
	localparam result_t END_ONLY = '{32'd0, 32'd0, 1'b0, 1'b1};

	localparam plan_row_t PLAN [29] = '{
		// defaults after reset: one-base sequences are shorter than the window
		'{1'b0, REG_MIN_GC, 32'd0, CHAR_C, 1'b1, 1'b1, END_ONLY},
		'{1'b0, REG_MIN_GC, 32'd0, 8'hFF, 1'b1, 1'b1, END_ONLY},
		'{1'b0, REG_MIN_GC, 32'd0, 8'h00, 1'b1, 1'b1, END_ONLY},
		// window of 5, 40..60 percent
		'{1'b1, REG_WIN_LEN, 32'd5, 8'h00, 1'b0, 1'b0, NO_RES},
		'{1'b1, REG_MIN_GC, 32'd40, 8'h00, 1'b0, 1'b0, NO_RES},
		'{1'b1, REG_MAX_GC, 32'd60, 8'h00, 1'b0, 1'b0, NO_RES},
		// first window qualifies, overlapping one merges, gap, then new region
		'{1'b0, REG_MIN_GC, 32'd0, CHAR_G, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, "A", 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, CHAR_C, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, "T", 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, "T", 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, "A", 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, CHAR_C, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, "c", 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, "g", 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, "a", 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, "t", 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, CHAR_G, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, CHAR_C, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, "T", 1'b1, 1'b0, NO_RES},
		// region that merges past the length limit is not reported, only the end marker
		'{1'b1, REG_MAX_REGION, 32'd5, 8'h00, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, CHAR_C, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, CHAR_G, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, "A", 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, "T", 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, "T", 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, CHAR_G, 1'b1, 1'b0, NO_RES},
		// zero window length acts as one
		'{1'b1, REG_WIN_LEN, 32'd0, 8'h00, 1'b0, 1'b0, NO_RES},
		'{1'b0, REG_MIN_GC, 32'd0, CHAR_C, 1'b1, 1'b0, NO_RES}
	};

	// Letters that do not count, some next to C and G in the code table
	localparam logic [7:0] NON_GC [10] = '{"A", "T", "N", "a", "c", "g", "B", "D", "F", "H"};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	gcr_base_if   base_ch ();
	gcr_region_if region_ch ();

	gc_content_region_finder #(
		.WINDOW_MAX (WIN_MAX)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.bases   (base_ch),
		.regions (region_ch)
	);

	// Predictor copy of the registers
	logic [6:0]  min_pct     = 7'd20;
	logic [6:0]  max_pct     = 7'd40;
	logic [12:0] win_reg     = 13'd50;
	logic [31:0] max_len_reg = 32'd1000;

	// Predictor copy of the stream state
	bit          gc_hist [WIN_MAX];
	logic [12:0] win_count  = '0;
	logic [31:0] seq_pos    = '0;
	logic [31:0] open_start = '0;
	logic [31:0] open_len   = '0;
	bit          open_valid = 1'b0;
	int unsigned hist_wr    = 0;
	int unsigned hist_fill  = 0;

	result_t due_regions [$];
	int      mismatch_count = 0;
	int      src_idle_pct   = 0;
	int      snk_idle_pct   = 0;
	int      seq_left       = 0;
	int      gc_pct         = 50;

	always #5 clk = ~clk;

	// Hard stop
	initial begin
		#10_000_000;
		$display("[gc_content_region_finder] ERROR");
		$finish;
	end

	task automatic flag(input string msg);
		if (mismatch_count < 50)
			$display("%0t mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic int unsigned win_span();
		if (win_reg == 0)
			return 1;
		if (win_reg > WIN_MAX)
			return WIN_MAX;
		return win_reg;
	endfunction

	// One base through the window count and region merge; returns result count
	function automatic int predict_base(input logic [7:0] b, input logic last,
		output result_t outs [2]);
		int unsigned     wl;
		bit              is_gc;
		longint unsigned scaled;
		logic [31:0]     s;
		int              n;
		wl = win_span();
		is_gc = (b == CHAR_C) || (b == CHAR_G);
		n = 0;
		outs[0] = '0;
		outs[1] = '0;
		// drop the base leaving the window
		if (hist_fill >= wl) begin
			if (gc_hist[(hist_wr + WIN_MAX - wl) % WIN_MAX] && win_count != 0)
				win_count--;
		end
		gc_hist[hist_wr] = is_gc;
		hist_wr = (hist_wr + 1) % WIN_MAX;
		if (is_gc && win_count != COUNT_MAX)
			win_count++;
		if (hist_fill < WIN_MAX)
			hist_fill++;
		// qualify test and merge
		if (hist_fill >= wl) begin
			scaled = 64'(win_count) * 64'(GC_SCALE);
			if (scaled >= 64'(min_pct) * wl && scaled <= 64'(max_pct) * wl) begin
				s = seq_pos + 32'd1 - wl;
				if (open_valid && (s - open_start) <= open_len) begin
					open_len = seq_pos + 32'd1 - open_start;
				end else begin
					if (open_valid && open_len <= max_len_reg) begin
						outs[n] = '{open_start, open_len, 1'b1, 1'b0};
						n++;
					end
					open_start = s;
					open_len = wl;
					open_valid = 1'b1;
				end
			end
		end
		// sequence end
		if (last) begin
			if (open_valid && open_len <= max_len_reg)
				outs[n] = '{open_start, open_len, 1'b1, 1'b1};
			else
				outs[n] = END_ONLY;
			n++;
			win_count = '0;
			seq_pos = '0;
			open_start = '0;
			open_len = '0;
			open_valid = 1'b0;
			hist_wr = 0;
			hist_fill = 0;
		end else begin
			seq_pos++;
		end
		return n;
	endfunction

	// Drive one base; called and returning at a rising edge
	task automatic send_base(input logic [7:0] b, input logic last, input logic typed,
		input result_t typed_res);
		result_t outs [2];
		int      n;
		while ($urandom_range(99) < src_idle_pct) begin
			base_ch.valid <= 1'b0;
			@(posedge clk);
		end
		base_ch.valid <= 1'b1;
		base_ch.base <= b;
		base_ch.last_base <= last;
		do @(negedge clk); while (!base_ch.ready);
		@(posedge clk);
		n = predict_base(b, last, outs);
		if (typed) begin
			due_regions.push_back(typed_res);
		end else begin
			for (int i = 0; i < n; i++)
				due_regions.push_back(outs[i]);
		end
	endtask

	// Hold off the sender until every result is out and the pipe is empty
	task automatic settle();
		base_ch.valid <= 1'b0;
		while (due_regions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// APB write, then read back
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		logic [31:0] want;
		case (idx)
			REG_MIN_GC: begin
				min_pct = val[6:0];
				want = {25'd0, val[6:0]};
			end
			REG_MAX_GC: begin
				max_pct = val[6:0];
				want = {25'd0, val[6:0]};
			end
			REG_WIN_LEN: begin
				win_reg = val[12:0];
				want = {19'd0, val[12:0]};
			end
			default: begin
				max_len_reg = val;
				want = val;
			end
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		if (prdata !== want)
			flag($sformatf("register %s reads %h, wrote %h", idx.name(), prdata, want));
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] pick_base(input int pct);
		if ($urandom_range(99) < 8)
			return 8'($urandom_range(255));
		if ($urandom_range(99) < pct)
			return $urandom_range(1) ? CHAR_C : CHAR_G;
		return NON_GC[$urandom_range(9)];
	endfunction

	// Random sequences; close ends the open sequence on the last base of the phase
	task automatic run_phase(input int n, input bit close);
		logic lst;
		for (int i = 0; i < n; i++) begin
			if (seq_left == 0) begin
				if ($urandom_range(4) == 0)
					seq_left = $urandom_range(1, win_span());
				else
					seq_left = $urandom_range(win_span(), 6 * win_span() + 8);
			end
			if ($urandom_range(win_span()) == 0)
				gc_pct = $urandom_range(100);
			lst = (seq_left == 1) || (close && i == n - 1);
			send_base(pick_base(gc_pct), lst, 1'b0, NO_RES);
			seq_left = lst ? 0 : seq_left - 1;
		end
	endtask

	task automatic apply_setting(input int k);
		logic [6:0]  lo;
		logic [6:0]  hi;
		logic [12:0] w;
		logic [31:0] cap;
		case (k)
			0: begin lo = 20; hi = 40; w = 5; cap = 1000; end
			1: begin lo = 0; hi = 100; w = 0; cap = 32'hFFFF_FFFF; end
			2: begin lo = 0; hi = 0; w = 7; cap = 1000; end
			3: begin lo = 100; hi = 100; w = 6; cap = 0; end
			4: begin lo = 127; hi = 127; w = 5; cap = 1000; end
			5: begin lo = 60; hi = 30; w = 8; cap = 1000; end
			6: begin lo = 50; hi = 127; w = 1; cap = 1; end
			7: begin lo = 0; hi = 100; w = 4096; cap = 1000; end
			default: begin
				lo = 7'($urandom_range(80));
				hi = lo + 7'($urandom_range(5, 30));
				w = 13'($urandom_range(2, 24));
				case ($urandom_range(2))
					0: cap = $urandom_range(w, 4 * w);
					1: cap = 1000;
					default: cap = 32'hFFFF_FFFF;
				endcase
			end
		endcase
		write_reg(REG_MIN_GC, 32'(lo));
		write_reg(REG_MAX_GC, 32'(hi));
		write_reg(REG_WIN_LEN, 32'(w));
		write_reg(REG_MAX_REGION, cap);
	endtask

	// Receiver stalls
	always @(posedge clk)
		region_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

	// Result checker: a transaction completes at the edge after this sample
	always @(negedge clk) begin : watch_regions
		result_t got;
		result_t want;
		if (arst_n && region_ch.valid === 1'b1 && region_ch.ready === 1'b1) begin
			got = '{region_ch.region_start, region_ch.region_length,
				region_ch.region_valid, region_ch.end_of_sequence};
			if (due_regions.size() == 0) begin
				flag($sformatf("unexpected result %h", got));
			end else begin
				want = due_regions.pop_front();
				if (got.region_start !== want.region_start)
					flag($sformatf("region_start %h, want %h", got.region_start,
						want.region_start));
				if (got.region_length !== want.region_length)
					flag($sformatf("region_length %h, want %h", got.region_length,
						want.region_length));
				if (got.region_valid !== want.region_valid)
					flag($sformatf("region_valid %b, want %b", got.region_valid,
						want.region_valid));
				if (got.end_of_sequence !== want.end_of_sequence)
					flag($sformatf("end_of_sequence %b, want %b", got.end_of_sequence,
						want.end_of_sequence));
			end
		end
	end

	initial begin
		int guard;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		base_ch.valid = 1'b0;
		base_ch.base = '0;
		base_ch.last_base = 1'b0;
		src_idle_pct = 21;
		snk_idle_pct = 49;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (PLAN[i]) begin
			if (PLAN[i].is_cfg) begin
				settle();
				write_reg(PLAN[i].idx, PLAN[i].val);
			end else begin
				send_base(PLAN[i].b, PLAN[i].last, PLAN[i].typed, PLAN[i].res);
			end
		end

		// random phases, some left open across a register change
		for (int k = 0; k < 16; k++) begin
			if (k < 6) begin
				src_idle_pct = 21;
				snk_idle_pct = 49;
			end else if (k < 11) begin
				src_idle_pct = 49;
				snk_idle_pct = 21;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			settle();
			apply_setting(k);
			run_phase(110, $urandom_range(3) != 0);
		end

		// oversized window register clamps to the full history depth
		settle();
		write_reg(REG_MIN_GC, 45);
		write_reg(REG_MAX_GC, 55);
		write_reg(REG_WIN_LEN, 13'h1FFF);
		write_reg(REG_MAX_REGION, 32'hFFFF_FFFF);
		gc_pct = 50;
		seq_left = 300;
		run_phase(300, 1'b1);

		// drain
		base_ch.valid <= 1'b0;
		guard = 0;
		while (due_regions.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (due_regions.size() != 0)
			flag($sformatf("%0d results never arrived", due_regions.size()));
		if (mismatch_count == 0)
			$display("[gc_content_region_finder] OK");
		else
			$display("[gc_content_region_finder] ERROR");
		$finish;
	end

endmodule
